// File: design/ms_adpcm_block_decoder_core_macros.svh
// Assertion macros for the block decoder core.
// Included by the top level; the clock is clk and the reset is rst.
`ifndef MS_ADPCM_BLOCK_DECODER_CORE_MACROS_SVH
`define MS_ADPCM_BLOCK_DECODER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MSADPCM_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define MSADPCM_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/msadpcm_pkg.sv
// Shared types, constants and tables for the ADPCM block decoder.
// No dependencies; every design module imports this package.
package msadpcm_pkg;

  localparam int MAX_COEF_PAIRS_DEF  = 8;
  localparam int MAX_BLOCK_BYTES_DEF = 4096;
  localparam int NUM_CHANNELS_DEF    = 2;

  localparam int QUEUE_DEPTH    = 2;
  localparam int IDX_W          = 3;
  localparam int COEF_REGS      = 4;
  localparam int COEF_REG_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int BLOCK_BYTES_W  = 13;
  localparam int COEF_COUNT_W   = 4;
  localparam int HDR_LEN_MONO   = 7;
  localparam int HDR_LEN_STEREO = 14;
  localparam int HDR_IDX_W      = 4;

  typedef enum logic [2:0] {
    REG_STEREO,
    REG_BLOCK_BYTES,
    REG_COEF_COUNT,
    REG_COEF_01,
    REG_COEF_23,
    REG_COEF_45,
    REG_COEF_67
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               last;
    logic               bad_block;
  } out_t;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_HDR,
    CMD_BAD
  } cmd_kind_t;

  // One unit of work for the back end: a data byte, a complete header or a rejected header.
  typedef struct packed {
    cmd_kind_t          kind;
    logic               stereo;
    logic [IDX_W-1:0]   idx0;
    logic [IDX_W-1:0]   idx1;
    logic signed [15:0] step0;
    logic signed [15:0] step1;
    logic signed [15:0] new0;
    logic signed [15:0] new1;
    logic signed [15:0] old0;
    logic signed [15:0] old1;
    logic [7:0]         data_byte;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_load;
  } back_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_SEED,
    B_MUL,
    B_PRED,
    B_WRITE,
    B_BAD
  } back_state_t;

  function automatic logic [10:0] step_factor(input logic [3:0] nib);
    logic [10:0] f;
    unique case (nib)
      4'h4, 4'hC: f = 11'd307;
      4'h5, 4'hB: f = 11'd409;
      4'h6, 4'hA: f = 11'd512;
      4'h7, 4'h9: f = 11'd614;
      4'h8:       f = 11'd768;
      default:    f = 11'd230;
    endcase
    return f;
  endfunction

endpackage

// File: design/msadpcm_front.sv
// Front end: takes stream bytes, tracks block position, gathers the header
// and hands classified commands to the queue. Depends on msadpcm_pkg.
module msadpcm_front #(
  parameter int MAX_COEF_PAIRS  = msadpcm_pkg::MAX_COEF_PAIRS_DEF,
  parameter int MAX_BLOCK_BYTES = msadpcm_pkg::MAX_BLOCK_BYTES_DEF,
  parameter int NUM_CHANNELS    = msadpcm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  msadpcm_pkg::in_t                       in_data,
  input  logic                                   stereo,
  input  logic [msadpcm_pkg::BLOCK_BYTES_W-1:0]  block_bytes,
  input  logic [msadpcm_pkg::COEF_COUNT_W-1:0]   coef_count,
  input  logic                                   q_full,
  output logic                                   push,
  output msadpcm_pkg::cmd_t                      cmd
);
  import msadpcm_pkg::*;

  localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int CMP_W = (POS_W > BLOCK_BYTES_W) ? POS_W : BLOCK_BYTES_W;

  logic [POS_W-1:0] block_position;
  logic             skipping;
  logic             skipping_next;
  logic [7:0]       header_store [HDR_LEN_STEREO];

  logic             st;
  logic             accept;
  logic             restart;
  logic             skip_eff;
  logic             is_hdr;
  logic             hdr_last;
  logic             ok0;
  logic             ok1;
  logic [POS_W-1:0] hlen;
  logic [POS_W-1:0] blen;
  logic [POS_W-1:0] p;
  logic [CMP_W-1:0] bb_ext;
  logic [7:0]       hb [HDR_LEN_STEREO];

  function automatic logic idx_ok(input logic [7:0] b, input logic [COEF_COUNT_W-1:0] cnt);
    return (b < 8'(cnt)) && (int'(b) < MAX_COEF_PAIRS);
  endfunction

  always_comb begin
    st     = stereo && (NUM_CHANNELS > 1);
    hlen   = st ? POS_W'(HDR_LEN_STEREO) : POS_W'(HDR_LEN_MONO);
    bb_ext = CMP_W'(block_bytes);
    if (bb_ext < CMP_W'(hlen)) begin
      blen = hlen;
    end else if (bb_ext > CMP_W'(MAX_BLOCK_BYTES)) begin
      blen = POS_W'(MAX_BLOCK_BYTES);
    end else begin
      blen = POS_W'(bb_ext);
    end
    restart  = in_data.block_start || (block_position >= blen);
    p        = restart ? '0 : block_position;
    skip_eff = skipping && !restart;
    is_hdr   = p < hlen;
    hdr_last = p == (hlen - POS_W'(1));
    // Header bytes with the arriving byte patched in at its own place.
    for (int i = 0; i < HDR_LEN_STEREO; i++) begin
      hb[i] = (p == POS_W'(i)) ? in_data.data_byte : header_store[i];
    end
    ok0 = idx_ok(hb[0], coef_count);
    ok1 = idx_ok(hb[1], coef_count) || !st;
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push          = accept && (is_hdr ? hdr_last : !skip_eff);
    skipping_next = skip_eff || (is_hdr && hdr_last && !(ok0 && ok1));

    cmd           = '0;
    cmd.stereo    = st;
    cmd.data_byte = in_data.data_byte;
    cmd.idx0      = hb[0][IDX_W-1:0];
    cmd.idx1      = hb[1][IDX_W-1:0];
    if (!is_hdr) begin
      cmd.kind = CMD_DATA;
    end else if (ok0 && ok1) begin
      cmd.kind = CMD_HDR;
    end else begin
      cmd.kind = CMD_BAD;
    end
    if (st) begin
      cmd.step0 = {hb[3], hb[2]};
      cmd.step1 = {hb[5], hb[4]};
      cmd.new0  = {hb[7], hb[6]};
      cmd.new1  = {hb[9], hb[8]};
      cmd.old0  = {hb[11], hb[10]};
      cmd.old1  = {hb[13], hb[12]};
    end else begin
      cmd.step0 = {hb[2], hb[1]};
      cmd.new0  = {hb[4], hb[3]};
      cmd.old0  = {hb[6], hb[5]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_position <= '0;
      skipping       <= 1'b0;
    end else if (accept) begin
      block_position <= p + POS_W'(1);
      skipping       <= skipping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_hdr) begin
      header_store[p[HDR_IDX_W-1:0]] <= in_data.data_byte;
    end
  end

endmodule

// File: design/msadpcm_queue.sv
// Short command queue between the front and back ends.
// Depends on msadpcm_pkg for the command type.
module msadpcm_queue #(
  parameter int DEPTH = msadpcm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  msadpcm_pkg::cmd_t wr_cmd,
  output logic              full,
  output logic              valid,
  output msadpcm_pkg::cmd_t rd_cmd,
  input  logic              pop
);
  import msadpcm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = count == CNT_W'(DEPTH);
  assign valid  = count != '0;
  assign rd_cmd = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// File: design/msadpcm_back.sv
// Back end: loads channel state from headers, decodes nibbles on a shared
// multiply datapath and drives the result register. Depends on msadpcm_pkg.
module msadpcm_back #(
  parameter int NUM_CHANNELS = msadpcm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    q_valid,
  input  msadpcm_pkg::cmd_t                                       q_cmd,
  output logic                                                    q_pop,
  input  logic [msadpcm_pkg::COEF_REGS-1:0][msadpcm_pkg::COEF_REG_W-1:0] coef_regs,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output msadpcm_pkg::out_t                                       out_data,
  output msadpcm_pkg::back_status_t                               status
);
  import msadpcm_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] RC = CH_W'(NUM_CHANNELS - 1);

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;
  logic [1:0]  cnt;

  logic signed [15:0] coef1  [NUM_CHANNELS];
  logic signed [15:0] coef2  [NUM_CHANNELS];
  logic signed [31:0] step   [NUM_CHANNELS];
  logic signed [15:0] newest [NUM_CHANNELS];
  logic signed [15:0] older  [NUM_CHANNELS];

  logic signed [31:0] pa;
  logic signed [31:0] pb;
  logic signed [24:0] pred;
  logic signed [35:0] sc;
  logic signed [43:0] sf;

  logic               slot_free;
  logic               seed_last;
  logic               out_load;
  logic [CH_W-1:0]    lane;
  logic [3:0]         nib;
  logic signed [3:0]  code;
  logic signed [11:0] factor;
  logic signed [32:0] psum;
  logic signed [36:0] s_full;
  logic signed [35:0] ns_full;
  logic signed [15:0] s_clamp;
  logic signed [31:0] ns_sat;
  logic [31:0]        pair0;
  logic [31:0]        pair1;
  out_t               res;

  function automatic logic [31:0] pick_pair(
    input logic [COEF_REGS-1:0][COEF_REG_W-1:0] regs,
    input logic [IDX_W-1:0] idx
  );
    logic [COEF_REG_W-1:0] r;
    r = regs[idx[IDX_W-1:1]];
    return idx[0] ? r[63:32] : r[31:0];
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_HDR:  state_next = B_LOAD;
            CMD_BAD:  state_next = B_BAD;
            CMD_DATA: state_next = B_MUL;
            default:  state_next = B_IDLE;
          endcase
        end
      end
      B_LOAD:  state_next = B_SEED;
      B_SEED:  if (slot_free && seed_last) state_next = B_IDLE;
      B_MUL:   state_next = B_PRED;
      B_PRED:  state_next = B_WRITE;
      B_WRITE: if (slot_free) state_next = cnt[0] ? B_IDLE : B_MUL;
      B_BAD:   if (slot_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Control strobes and datapath selects
  always_comb begin
    slot_free = !out_valid || out_ready;
    seed_last = cur.stereo ? (cnt == 2'd3) : (cnt == 2'd1);
    q_pop     = (state == B_IDLE) && q_valid;
    out_load  = slot_free && ((state == B_SEED) || (state == B_WRITE) || (state == B_BAD));
    if (state == B_SEED) begin
      lane = (cur.stereo && cnt[1]) ? RC : '0;
    end else begin
      lane = (cur.stereo && cnt[0]) ? RC : '0;
    end
    nib    = cnt[0] ? cur.data_byte[3:0] : cur.data_byte[7:4];
    code   = signed'(nib);
    factor = signed'({1'b0, step_factor(nib)});
    psum   = 33'(pa) + 33'(pb);
    pair0  = pick_pair(coef_regs, cur.idx0);
    pair1  = pick_pair(coef_regs, cur.idx1);

    s_full  = 37'(sc) + 37'(pred);
    ns_full = sf[43:8];
    if (s_full > 37'sd32767) begin
      s_clamp = 16'sh7FFF;
    end else if (s_full < -37'sd32768) begin
      s_clamp = 16'sh8000;
    end else begin
      s_clamp = s_full[15:0];
    end
    if (ns_full > 36'sd2147483647) begin
      ns_sat = 32'sh7FFFFFFF;
    end else if (ns_full < 36'sd16) begin
      ns_sat = 32'sd16;
    end else begin
      ns_sat = ns_full[31:0];
    end

    res = '0;
    unique case (state)
      B_SEED: begin
        res.sample  = cnt[0] ? newest[lane] : older[lane];
        res.channel = cur.stereo && cnt[1];
        res.last    = seed_last;
      end
      B_WRITE: begin
        res.sample  = s_clamp;
        res.channel = cur.stereo && cnt[0];
        res.last    = cnt[0];
      end
      B_BAD: begin
        res.last      = 1'b1;
        res.bad_block = 1'b1;
      end
      default: res = '0;
    endcase

    status.busy     = state != B_IDLE;
    status.out_load = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cnt <= '0;
      end else if (out_load && ((state == B_SEED) || (state == B_WRITE))) begin
        cnt <= cnt + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (out_load) begin
      out_data <= res;
    end
    if (state == B_MUL) begin
      pa <= coef1[lane] * newest[lane];
      pb <= coef2[lane] * older[lane];
    end
    if (state == B_PRED) begin
      pred <= psum[32:8];
      sc   <= step[lane] * code;
      sf   <= step[lane] * factor;
    end
    if ((state == B_WRITE) && out_load) begin
      step[lane]   <= ns_sat;
      older[lane]  <= newest[lane];
      newest[lane] <= s_clamp;
    end
    if (state == B_LOAD) begin
      coef1[0]  <= pair0[15:0];
      coef2[0]  <= pair0[31:16];
      step[0]   <= 32'(cur.step0);
      newest[0] <= cur.new0;
      older[0]  <= cur.old0;
      if (cur.stereo && (NUM_CHANNELS > 1)) begin
        coef1[RC]  <= pair1[15:0];
        coef2[RC]  <= pair1[31:16];
        step[RC]   <= 32'(cur.step1);
        newest[RC] <= cur.new1;
        older[RC]  <= cur.old1;
      end
    end
  end

endmodule

// File: design/ms_adpcm_block_decoder_core.sv
// Top level of the ADPCM block decoder: configuration registers, front end,
// command queue and back end. Depends on msadpcm_pkg and the macros header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | sink      | in_valid / in_ready  | in_data   (data_byte, block_start)
//   out     | source    | out_valid / out_ready| out_data  (sample, channel, last, bad_block)
//   cfg     | sink      | cfg_write            | cfg_index, cfg_data
//
// A header byte other than the last is only stored in the front end.
// Every command leaves the queue while the back end is idle. A header then
// loads and sends 2 (mono) or 4 (stereo) seed samples, one per cycle while the
// result register is free; a rejected header gives 1 result. A data byte is
// dequeued, then each nibble goes through coefficient products, prediction and
// step products, and the write. The 2-entry command queue lets the front keep
// taking bytes while the back end or the result register stalls. Reset is
// synchronous and needs no clearing pass.
module ms_adpcm_block_decoder_core #(
  parameter int MAX_COEF_PAIRS  = msadpcm_pkg::MAX_COEF_PAIRS_DEF,
  parameter int MAX_BLOCK_BYTES = msadpcm_pkg::MAX_BLOCK_BYTES_DEF,
  parameter int NUM_CHANNELS    = msadpcm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  msadpcm_pkg::in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output msadpcm_pkg::out_t                   out_data,
  input  logic                                cfg_write,
  input  logic [msadpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msadpcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import msadpcm_pkg::*;

`include "ms_adpcm_block_decoder_core_macros.svh"

  logic                                  stereo;
  logic [BLOCK_BYTES_W-1:0]              block_bytes;
  logic [COEF_COUNT_W-1:0]               coef_count;
  logic [COEF_REGS-1:0][COEF_REG_W-1:0]  coef_regs;

  logic         q_push;
  logic         q_full;
  logic         q_valid;
  logic         q_pop;
  cmd_t         q_wr_cmd;
  cmd_t         q_rd_cmd;
  back_status_t bk_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo      <= 1'b0;
      block_bytes <= BLOCK_BYTES_W'(256);
      coef_count  <= COEF_COUNT_W'(7);
      coef_regs   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEREO:      stereo       <= cfg_data[0];
        REG_BLOCK_BYTES: block_bytes  <= cfg_data[BLOCK_BYTES_W-1:0];
        REG_COEF_COUNT:  coef_count   <= cfg_data[COEF_COUNT_W-1:0];
        REG_COEF_01:     coef_regs[0] <= cfg_data;
        REG_COEF_23:     coef_regs[1] <= cfg_data;
        REG_COEF_45:     coef_regs[2] <= cfg_data;
        REG_COEF_67:     coef_regs[3] <= cfg_data;
        default:         coef_count   <= coef_count;
      endcase
    end
  end

  msadpcm_front #(
    .MAX_COEF_PAIRS  (MAX_COEF_PAIRS),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .NUM_CHANNELS    (NUM_CHANNELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .stereo      (stereo),
    .block_bytes (block_bytes),
    .coef_count  (coef_count),
    .q_full      (q_full),
    .push        (q_push),
    .cmd         (q_wr_cmd)
  );

  msadpcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .valid  (q_valid),
    .rd_cmd (q_rd_cmd),
    .pop    (q_pop)
  );

  msadpcm_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_rd_cmd),
    .q_pop     (q_pop),
    .coef_regs (coef_regs),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (bk_status)
  );

  `MSADPCM_CHECK(a_push_has_room, q_push, !q_full, "command pushed into a full queue")
  `MSADPCM_CHECK(a_no_result_overwrite, out_valid && !out_ready, !bk_status.out_load, "result register overwritten while stalled")
  `MSADPCM_CHECK(a_bad_block_form, out_valid && out_data.bad_block, (out_data.sample == 16'sd0) && out_data.last, "rejected block result not zero and last")
  `MSADPCM_CHECK_NEXT(a_pop_starts_work, q_pop, bk_status.busy, "back end idle after taking a command")

endmodule
